// ----- rtl/lbd_pkg.sv -----
// ----------------------------------------------------------------------------
// lbd_pkg
// Shared types and constants for the birth-death next-reaction step block.
// ----------------------------------------------------------------------------
package lbd_pkg;

    // command codes
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_INIT_COUNT = 2'd0;
    localparam logic [1:0] REG_COEFF      = 2'd1;
    localparam logic [1:0] REG_END_TIME   = 2'd2;
    localparam logic [1:0] REG_KNOT_COUNT = 2'd3;

    localparam logic [31:0] ALL32   = 32'hFFFF_FFFF;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef enum logic [1:0] {
        K_BIRTH = 2'd0,
        K_DEATH = 2'd1,
        K_NONE  = 2'd2,
        K_DONE  = 2'd3
    } t_kind;

    typedef enum logic [5:0] {
        S_IDLE, S_SPC, S_ST_M0, S_ST_M1,
        S_LN0, S_LN_NORM, S_LN_SQ, S_LN_SQW, S_LN_L, S_LN_LW,
        S_RATE0, S_RATE1, S_RATE_IDX, S_RATE_FR, S_RATE_LO, S_RATE_HI,
        S_RATE_DM, S_RATE_DW, S_RATE_END,
        S_PB, S_PB_W, S_PQ_W, S_PX_W, S_PD_W,
        S_W0, S_WW, S_WSEL, S_IT0W, S_IT1W, S_MARK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

endpackage

// ----- rtl/lbd_mul.sv -----
// ----------------------------------------------------------------------------
// lbd_mul
// Shared 32x32 unsigned multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module lbd_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // register the product every cycle
    always_ff @(posedge i_clk) begin
        r_p <= {32'd0, i_a} * {32'd0, i_b};
    end

    assign o_p = r_p;

endmodule

// ----- rtl/lbd_div.sv -----
// ----------------------------------------------------------------------------
// lbd_div
// Shared restoring divider, 64-bit numerator by 32-bit divisor, one
// quotient bit per cycle; done pulses as the last bit is registered.
// ----------------------------------------------------------------------------
module lbd_div
    import lbd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_q;
    logic [31:0] r_den;
    logic [32:0] w_sh;
    logic [32:0] w_diff;
    logic        w_ge;

    // trial subtract of the shifted remainder
    always_comb begin
        w_sh   = {r_rem, r_q[63]};
        w_ge   = (w_sh >= {1'b0, r_den});
        w_diff = w_sh - {1'b0, r_den};
    end

    // advance one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_q    <= '0;
            r_den  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[31:0] : w_sh[31:0];
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ----- rtl/logistic_birth_death_nrm_step.sv -----
// ----------------------------------------------------------------------------
// logistic_birth_death_nrm_step
// Sequence: a load goes from idle straight to the result state; start and
// event steps, steps without an event and unused commands run the rate
// lookup on the shared divider, and start and event steps also run the 16
// squarings of the log unit. Handshake: one command at a time; busy stays
// high until the result, which shows for one cycle with o_valid; no stall.
// Reset (synchronous, active low) clears population, time, marks, rates.
// ----------------------------------------------------------------------------
module logistic_birth_death_nrm_step
    import lbd_pkg::*;
#(
    parameter int MAX_KNOTS  = 16,
    parameter int COUNT_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_cmd,
    input  logic [3:0]            i_knot_index,
    input  logic [31:0]           i_knot_value,
    input  logic [31:0]           i_rand_first,
    input  logic [31:0]           i_rand_second,
    input  logic [31:0]           i_stop_time,
    output logic                  o_valid,
    output logic [1:0]            o_event_kind,
    output logic [COUNT_BITS-1:0] o_cell_count,
    output logic [31:0]           o_sim_time,
    output logic [31:0]           o_birth_rate_now
);

    localparam int KIW = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
    localparam int NW  = $clog2(MAX_KNOTS + 1);
    localparam logic [31:0] CMAX32 = 32'((64'd1 << COUNT_BITS) - 64'd1);

    function automatic logic [31:0] sat32(input logic [63:0] v);
        sat32 = (v[63:32] != 32'd0) ? ALL32 : v[31:0];
    endfunction

    function automatic logic [31:0] sat_add48(input logic [31:0] a,
                                              input logic [47:0] b);
        logic [48:0] s;
        s = {17'd0, a} + {1'b0, b};
        sat_add48 = (s[48:32] != 17'd0) ? ALL32 : s[31:0];
    endfunction

    // configuration registers
    logic [19:0] r_init_count;
    logic [31:0] r_coeff;
    logic [31:0] r_end_time;
    logic [4:0]  r_knot_count;
    logic        w_cfg_wr;

    // knot memory
    logic [31:0]    r_knot_mem [MAX_KNOTS];
    logic [31:0]    r_knot_rd;
    logic [KIW-1:0] w_raddr;
    logic           w_accept;

    // sequencer state and datapath registers
    t_state                r_state, n_state, r_ret, n_ret;
    t_kind                 r_kind, n_kind;
    logic [31:0]           r_r1, n_r1, r_r2, n_r2;
    logic [COUNT_BITS-1:0] r_pop, n_pop;
    logic [31:0]           r_time, n_time, r_spacing, n_spacing;
    logic [31:0]           r_it [2];
    logic [31:0]           n_it [2];
    logic [31:0]           r_pm [2];
    logic [31:0]           n_pm [2];
    logic [31:0]           r_pr [2];
    logic [31:0]           n_pr [2];
    logic [31:0]           r_rate, n_rate;
    logic                  r_do_props, n_do_props;
    logic [31:0]           r_lnarg, n_lnarg, r_lnres, n_lnres;
    logic [31:0]           r_m, n_m;
    logic [4:0]            r_e, n_e;
    logic [15:0]           r_f, n_f;
    logic [3:0]            r_cnt, n_cnt;
    logic [31:0]           r_last, n_last;
    logic [KIW-1:0]        r_idx, n_idx;
    logic [31:0]           r_frac, n_frac, r_lo, n_lo;
    logic                  r_neg, n_neg;
    logic [31:0]           r_qb, n_qb;
    logic                  r_widx, n_widx, r_best_v, n_best_v, r_best, n_best;
    logic [31:0]           r_bw, n_bw;

    // shared units
    logic [31:0] w_mul_a, w_mul_b;
    logic [63:0] w_mul_p;
    t_div_req    w_div_req;
    t_div_rsp    w_div_rsp;

    // helpers
    logic [NW-1:0]         w_nused;
    logic [NW-1:0]         w_nm1;
    logic [COUNT_BITS-1:0] w_init_clamp;
    logic [32:0]           w_sq;
    logic [21:0]           w_lval;
    logic [31:0]           w_diff;
    logic [31:0]           w_wait;
    logic [32:0]           w_tsum;

    lbd_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    lbd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // APB access
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_INIT_COUNT: prdata = {12'd0, r_init_count};
            REG_COEFF:      prdata = r_coeff;
            REG_END_TIME:   prdata = r_end_time;
            REG_KNOT_COUNT: prdata = {27'd0, r_knot_count};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_count <= 20'd100;
            r_coeff      <= 32'd0;
            r_end_time   <= 32'd65536;
            r_knot_count <= 5'd2;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_INIT_COUNT: r_init_count <= pwdata[19:0];
                REG_COEFF:      r_coeff      <= pwdata;
                REG_END_TIME:   r_end_time   <= pwdata;
                REG_KNOT_COUNT: r_knot_count <= pwdata[4:0];
                default:        r_coeff      <= r_coeff;
            endcase
        end
    end

    // knot store: write on load transfer, registered read
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_cmd == CMD_LOAD) && (32'(i_knot_index) < MAX_KNOTS)) begin
            r_knot_mem[KIW'(i_knot_index)] <= i_knot_value;
        end
        r_knot_rd <= r_knot_mem[w_raddr];
    end

    // clamp knot count and initial count
    always_comb begin
        if (r_knot_count < 5'd2) begin
            w_nused = NW'(2);
        end else if (32'(r_knot_count) > MAX_KNOTS) begin
            w_nused = NW'(MAX_KNOTS);
        end else begin
            w_nused = NW'(r_knot_count);
        end
        w_nm1 = w_nused - NW'(1);
        if ({12'd0, r_init_count} > CMAX32) begin
            w_init_clamp = COUNT_BITS'(CMAX32);
        end else begin
            w_init_clamp = COUNT_BITS'(r_init_count);
        end
    end

    // sequencer: next state and datapath
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_kind     = r_kind;
        n_r1       = r_r1;
        n_r2       = r_r2;
        n_pop      = r_pop;
        n_time     = r_time;
        n_spacing  = r_spacing;
        n_it       = r_it;
        n_pm       = r_pm;
        n_pr       = r_pr;
        n_rate     = r_rate;
        n_do_props = r_do_props;
        n_lnarg    = r_lnarg;
        n_lnres    = r_lnres;
        n_m        = r_m;
        n_e        = r_e;
        n_f        = r_f;
        n_cnt      = r_cnt;
        n_last     = r_last;
        n_idx      = r_idx;
        n_frac     = r_frac;
        n_lo       = r_lo;
        n_neg      = r_neg;
        n_qb       = r_qb;
        n_widx     = r_widx;
        n_best_v   = r_best_v;
        n_best     = r_best;
        n_bw       = r_bw;
        w_mul_a    = 32'd0;
        w_mul_b    = 32'd0;
        w_div_req  = '0;
        w_raddr    = r_idx;
        w_sq       = w_mul_p[63:31];
        w_lval     = {6'd32 - {1'b0, r_e}, 16'd0} - {6'd0, r_f};
        w_diff     = (r_pm[r_widx] > r_it[r_widx]) ? (r_pm[r_widx] - r_it[r_widx]) : 32'd0;
        w_wait     = sat32(w_div_rsp.quot);
        w_tsum     = {1'b0, r_time} + {1'b0, r_bw};

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_r1       = i_rand_first;
                    n_r2       = i_rand_second;
                    n_do_props = 1'b0;
                    priority case (i_cmd)
                        CMD_LOAD: begin
                            n_kind  = K_DONE;
                            n_rate  = 32'd0;
                            n_state = S_OUT;
                        end
                        CMD_START: begin
                            n_pop         = w_init_clamp;
                            n_time        = 32'd0;
                            n_it[0]       = 32'd0;
                            n_it[1]       = 32'd0;
                            n_kind        = K_DONE;
                            w_div_req.start = 1'b1;
                            w_div_req.num = {32'd0, r_end_time};
                            w_div_req.den = 32'(w_nm1);
                            n_state       = S_SPC;
                        end
                        CMD_STEP: begin
                            if (r_time < i_stop_time) begin
                                n_widx   = 1'b0;
                                n_best_v = 1'b0;
                                n_state  = S_W0;
                            end else begin
                                n_kind  = K_NONE;
                                n_state = S_RATE0;
                            end
                        end
                        default: begin
                            n_kind  = K_NONE;
                            n_state = S_RATE0;
                        end
                    endcase
                end
            end
            // start: spacing, then both marks
            S_SPC: begin
                if (w_div_rsp.done) begin
                    n_spacing = w_div_rsp.quot[31:0];
                    n_lnarg   = r_r1;
                    n_ret     = S_ST_M0;
                    n_state   = S_LN0;
                end
            end
            S_ST_M0: begin
                n_pm[0] = r_lnres;
                n_lnarg = r_r2;
                n_ret   = S_ST_M1;
                n_state = S_LN0;
            end
            S_ST_M1: begin
                n_pm[1]    = r_lnres;
                n_do_props = 1'b1;
                n_state    = S_RATE0;
            end
            // -ln(r): normalize, square 16 times, scale by ln 2
            S_LN0: begin
                if (r_lnarg == 32'd0) begin
                    n_lnres = ALL32;
                    n_state = r_ret;
                end else begin
                    n_m     = r_lnarg;
                    n_e     = 5'd31;
                    n_state = S_LN_NORM;
                end
            end
            S_LN_NORM: begin
                if (r_m[31]) begin
                    n_f     = 16'd0;
                    n_cnt   = 4'd0;
                    n_state = S_LN_SQ;
                end else begin
                    n_m = {r_m[30:0], 1'b0};
                    n_e = r_e - 5'd1;
                end
            end
            S_LN_SQ: begin
                w_mul_a = r_m;
                w_mul_b = r_m;
                n_state = S_LN_SQW;
            end
            S_LN_SQW: begin
                n_f   = {r_f[14:0], w_sq[32]};
                n_m   = w_sq[32] ? w_sq[32:1] : w_sq[31:0];
                n_cnt = r_cnt + 4'd1;
                n_state = (r_cnt == 4'd15) ? S_LN_L : S_LN_SQ;
            end
            S_LN_L: begin
                w_mul_a = {10'd0, w_lval};
                w_mul_b = LN2_Q32;
                n_state = S_LN_LW;
            end
            S_LN_LW: begin
                n_lnres = w_mul_p[63:32];
                n_state = r_ret;
            end
            // rate lookup at current time
            S_RATE0: begin
                w_raddr = KIW'(w_nm1);
                n_state = S_RATE1;
            end
            S_RATE1: begin
                n_last = r_knot_rd;
                if ((r_time >= r_end_time) || (r_spacing == 32'd0)) begin
                    n_rate  = r_knot_rd;
                    n_state = S_RATE_END;
                end else begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = {32'd0, r_time};
                    w_div_req.den   = r_spacing;
                    n_state         = S_RATE_IDX;
                end
            end
            S_RATE_IDX: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quot >= 64'(w_nm1)) begin
                        n_rate  = r_last;
                        n_state = S_RATE_END;
                    end else begin
                        n_idx   = KIW'(w_div_rsp.quot);
                        w_mul_a = w_div_rsp.quot[31:0];
                        w_mul_b = r_spacing;
                        n_state = S_RATE_FR;
                    end
                end
            end
            S_RATE_FR: begin
                n_frac  = r_time - w_mul_p[31:0];
                w_raddr = r_idx;
                n_state = S_RATE_LO;
            end
            S_RATE_LO: begin
                n_lo    = r_knot_rd;
                w_raddr = r_idx + KIW'(1);
                n_state = S_RATE_HI;
            end
            S_RATE_HI: begin
                if (r_knot_rd >= r_lo) begin
                    n_neg   = 1'b0;
                    w_mul_a = r_knot_rd - r_lo;
                end else begin
                    n_neg   = 1'b1;
                    w_mul_a = r_lo - r_knot_rd;
                end
                w_mul_b = r_frac;
                n_state = S_RATE_DM;
            end
            S_RATE_DM: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = w_mul_p;
                w_div_req.den   = r_spacing;
                n_state         = S_RATE_DW;
            end
            S_RATE_DW: begin
                if (w_div_rsp.done) begin
                    n_rate  = r_neg ? (r_lo - w_div_rsp.quot[31:0])
                                    : (r_lo + w_div_rsp.quot[31:0]);
                    n_state = S_RATE_END;
                end
            end
            S_RATE_END: begin
                n_state = r_do_props ? S_PB : S_OUT;
            end
            // propensities
            S_PB: begin
                w_mul_a = 32'(r_pop);
                w_mul_b = r_rate;
                n_state = S_PB_W;
            end
            S_PB_W: begin
                n_pr[0] = sat32(w_mul_p);
                if (32'(r_pop) <= 32'd1) begin
                    n_pr[1] = 32'd0;
                    n_state = S_OUT;
                end else begin
                    w_mul_a = r_coeff;
                    w_mul_b = r_rate;
                    n_state = S_PQ_W;
                end
            end
            S_PQ_W: begin
                n_qb    = sat32({16'd0, w_mul_p[63:16]});
                w_mul_a = 32'(r_pop) - 32'd1;
                w_mul_b = 32'(r_pop);
                n_state = S_PX_W;
            end
            S_PX_W: begin
                if (r_qb == 32'd0) begin
                    n_pr[1] = 32'd0;
                    n_state = S_OUT;
                end else if (w_mul_p[63:32] != 32'd0) begin
                    n_pr[1] = ALL32;
                    n_state = S_OUT;
                end else begin
                    w_mul_a = w_mul_p[31:0];
                    w_mul_b = r_qb;
                    n_state = S_PD_W;
                end
            end
            S_PD_W: begin
                n_pr[1] = sat32(w_mul_p);
                n_state = S_OUT;
            end
            // event: waits of both reactions
            S_W0: begin
                if (r_pr[r_widx] != 32'd0) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = {16'd0, w_diff, 16'd0};
                    w_div_req.den   = r_pr[r_widx];
                    n_state         = S_WW;
                end else if (r_widx) begin
                    n_state = S_WSEL;
                end else begin
                    n_widx = 1'b1;
                end
            end
            S_WW: begin
                if (w_div_rsp.done) begin
                    if (!r_best_v || (w_wait < r_bw)) begin
                        n_best_v = 1'b1;
                        n_best   = r_widx;
                        n_bw     = w_wait;
                    end
                    if (r_widx) begin
                        n_state = S_WSEL;
                    end else begin
                        n_widx  = 1'b1;
                        n_state = S_W0;
                    end
                end
            end
            S_WSEL: begin
                if (!r_best_v) begin
                    n_kind  = K_NONE;
                    n_state = S_RATE0;
                end else begin
                    n_time = w_tsum[32] ? ALL32 : w_tsum[31:0];
                    if (!r_best) begin
                        n_kind = K_BIRTH;
                        if (32'(r_pop) < CMAX32) n_pop = r_pop + COUNT_BITS'(1);
                    end else begin
                        n_kind = K_DEATH;
                        if (r_pop != '0) n_pop = r_pop - COUNT_BITS'(1);
                    end
                    w_mul_a = r_pr[0];
                    w_mul_b = r_bw;
                    n_state = S_IT0W;
                end
            end
            S_IT0W: begin
                n_it[0] = sat_add48(r_it[0], w_mul_p[63:16]);
                w_mul_a = r_pr[1];
                w_mul_b = r_bw;
                n_state = S_IT1W;
            end
            S_IT1W: begin
                n_it[1] = sat_add48(r_it[1], w_mul_p[63:16]);
                n_lnarg = r_r1;
                n_ret   = S_MARK;
                n_state = S_LN0;
            end
            S_MARK: begin
                n_pm[r_best] = sat_add48(r_pm[r_best], {16'd0, r_lnres});
                n_do_props   = 1'b1;
                n_state      = S_RATE0;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_kind     <= K_NONE;
            r_pop      <= '0;
            r_time     <= '0;
            r_spacing  <= '0;
            r_it       <= '{default: '0};
            r_pm       <= '{default: '0};
            r_pr       <= '{default: '0};
            r_rate     <= '0;
            r_do_props <= 1'b0;
            r_widx     <= 1'b0;
            r_best_v   <= 1'b0;
            r_best     <= 1'b0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_kind     <= n_kind;
            r_pop      <= n_pop;
            r_time     <= n_time;
            r_spacing  <= n_spacing;
            r_it       <= n_it;
            r_pm       <= n_pm;
            r_pr       <= n_pr;
            r_rate     <= n_rate;
            r_do_props <= n_do_props;
            r_widx     <= n_widx;
            r_best_v   <= n_best_v;
            r_best     <= n_best;
            r_cnt      <= n_cnt;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_r1    <= n_r1;
        r_r2    <= n_r2;
        r_lnarg <= n_lnarg;
        r_lnres <= n_lnres;
        r_m     <= n_m;
        r_e     <= n_e;
        r_f     <= n_f;
        r_last  <= n_last;
        r_idx   <= n_idx;
        r_frac  <= n_frac;
        r_lo    <= n_lo;
        r_neg   <= n_neg;
        r_qb    <= n_qb;
        r_bw    <= n_bw;
    end

    // outputs
    assign busy             = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_OUT);
    assign o_event_kind     = r_kind;
    assign o_cell_count     = r_pop;
    assign o_sim_time       = r_time;
    assign o_birth_rate_now = r_rate;

    // checks
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    a_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result shown while idle");

    a_load_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_cmd == CMD_LOAD)) |=> o_valid)
        else $error("load did not complete in one cycle");

endmodule

// ----- tb/logistic_birth_death_nrm_step_tb.sv -----
// ----------------------------------------------------------------------------
// logistic_birth_death_nrm_step_tb
// Drives knot loads, start, step and unused commands into the birth-death
// next-reaction block across several register settings. A local predictor
// tracks the population, time, marks and propensities and checks every result.
// ----------------------------------------------------------------------------
module logistic_birth_death_nrm_step_tb;
    import lbd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          KNOTS      = 16;
    localparam logic [19:0] COUNT_MAX  = 20'hFFFFF;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int          PHASES     = 8;
    localparam int          PHASE_ITEMS = 186;

    typedef struct {
        t_kind       kind;
        logic [19:0] count;
        logic [31:0] simt;
        logic [31:0] rate;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  i_cmd = '0;
    logic [3:0]  i_knot_index = '0;
    logic [31:0] i_knot_value = '0;
    logic [31:0] i_rand_first = 32'd1;
    logic [31:0] i_rand_second = 32'd1;
    logic [31:0] i_stop_time = '0;
    logic        o_valid;
    logic [1:0]  o_event_kind;
    logic [19:0] o_cell_count;
    logic [31:0] o_sim_time;
    logic [31:0] o_birth_rate_now;

    // predictor copy of registers and state
    logic [19:0] cfg_init_count = 20'd100;
    logic [31:0] cfg_coeff = '0;
    logic [31:0] cfg_end_time = 32'd65536;
    logic [4:0]  cfg_knot_count = 5'd2;
    logic [31:0] knot_rate [KNOTS];
    logic [19:0] cells = '0;
    logic [31:0] now_time = '0;
    logic [31:0] spacing = '0;
    logic [31:0] clock_int [2] = '{32'd0, 32'd0};
    logic [31:0] mark [2] = '{32'd0, 32'd0};
    logic [31:0] propensity [2] = '{32'd0, 32'd0};

    t_outcome pending_outcomes[$];
    int errors = 0;
    int items_sent = 0;
    int births = 0, deaths = 0, idles = 0, dones = 0;

    logistic_birth_death_nrm_step u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_knot_index(i_knot_index), .i_knot_value(i_knot_value),
        .i_rand_first(i_rand_first), .i_rand_second(i_rand_second),
        .i_stop_time(i_stop_time),
        .o_valid(o_valid), .o_event_kind(o_event_kind), .o_cell_count(o_cell_count),
        .o_sim_time(o_sim_time), .o_birth_rate_now(o_birth_rate_now)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------- predictor ----------------

    function automatic logic [31:0] sat32(input logic [127:0] v);
        return (v > 128'hFFFF_FFFF) ? ALL32 : v[31:0];
    endfunction

    function automatic logic [31:0] neg_log(input logic [31:0] r);
        int          e;
        logic [63:0] m;
        logic [15:0] f;
        logic [63:0] l;
        logic [63:0] p;
        if (r == 0) return ALL32;
        e = 31;
        while (!r[e]) e--;
        m = 64'(r) << (31 - e);
        f = '0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 31;
            f = {f[14:0], 1'b0};
            if (m >= 64'h1_0000_0000) begin
                f[0] = 1'b1;
                m = m >> 1;
            end
        end
        l = (64'(32 - e) << 16) - 64'(f);
        p = l * 64'(LN2_Q32);
        return p[63:32];
    endfunction

    function automatic int knots_in_use();
        int n;
        n = cfg_knot_count;
        if (n < 2) n = 2;
        if (n > KNOTS) n = KNOTS;
        return n;
    endfunction

    function automatic logic [31:0] birth_rate_at(input logic [31:0] t);
        int          n;
        logic [63:0] idx, frac, lo, hi;
        n = knots_in_use();
        if (t >= cfg_end_time || spacing == 0) return knot_rate[n-1];
        idx = 64'(t) / 64'(spacing);
        if (idx >= 64'(n - 1)) return knot_rate[n-1];
        frac = 64'(t) - idx * 64'(spacing);
        lo = 64'(knot_rate[idx]);
        hi = 64'(knot_rate[idx+1]);
        if (hi >= lo) return 32'(lo + ((hi - lo) * frac) / 64'(spacing));
        return 32'(lo - ((lo - hi) * frac) / 64'(spacing));
    endfunction

    function automatic void refresh_propensities();
        logic [31:0]  b;
        logic [127:0] x;
        logic [31:0]  qb;
        b = birth_rate_at(now_time);
        x = 128'(cells);
        propensity[0] = sat32(x * 128'(b));
        if (x <= 1) begin
            propensity[1] = '0;
        end else begin
            qb = sat32((128'(cfg_coeff) * 128'(b)) >> 16);
            propensity[1] = sat32((x - 1) * x * 128'(qb));
        end
    endfunction

    function automatic t_outcome advance_population(input logic [1:0] cmd,
            input logic [3:0] kidx, input logic [31:0] kval,
            input logic [31:0] r1, input logic [31:0] r2, input logic [31:0] stop);
        t_outcome    res;
        int          best;
        logic [31:0] bw, w;
        logic [63:0] diff;
        res.kind = K_NONE;
        res.rate = '0;
        case (cmd)
            CMD_LOAD: begin
                knot_rate[kidx] = kval;
                res.kind = K_DONE;
            end
            CMD_START: begin
                cells = cfg_init_count;
                now_time = '0;
                spacing = cfg_end_time / 32'(knots_in_use() - 1);
                clock_int[0] = '0;
                clock_int[1] = '0;
                mark[0] = neg_log(r1);
                mark[1] = neg_log(r2);
                refresh_propensities();
                res.kind = K_DONE;
            end
            CMD_STEP: begin
                if (now_time < stop) begin
                    best = -1;
                    bw = '0;
                    for (int i = 0; i < 2; i++) begin
                        if (propensity[i] != 0) begin
                            diff = (mark[i] > clock_int[i]) ?
                                64'(mark[i] - clock_int[i]) : 64'd0;
                            w = sat32(128'((diff << 16) / 64'(propensity[i])));
                            if (best < 0 || w < bw) begin
                                best = i;
                                bw = w;
                            end
                        end
                    end
                    if (best >= 0) begin
                        now_time = sat32(128'(now_time) + 128'(bw));
                        if (best == 0) begin
                            if (cells < COUNT_MAX) cells = cells + 1'b1;
                        end else if (cells > 0) begin
                            cells = cells - 1'b1;
                        end
                        for (int i = 0; i < 2; i++)
                            clock_int[i] = sat32(128'(clock_int[i]) +
                                ((128'(propensity[i]) * 128'(bw)) >> 16));
                        mark[best] = sat32(128'(mark[best]) + 128'(neg_log(r1)));
                        refresh_propensities();
                        res.kind = (best == 0) ? K_BIRTH : K_DEATH;
                    end
                end
            end
            default: ;
        endcase
        if (cmd != CMD_LOAD) res.rate = birth_rate_at(now_time);
        res.count = cells;
        res.simt = now_time;
        return res;
    endfunction

    // ---------------- drivers ----------------

    // setup phase and access phase, then idle
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_INIT_COUNT: cfg_init_count = val[19:0];
            REG_COEFF:      cfg_coeff = val;
            REG_END_TIME:   cfg_end_time = val;
            default:        cfg_knot_count = val[4:0];
        endcase
    endtask

    // hold the command until the block takes it, then queue its outcome
    task automatic send_item(input logic [1:0] cmd, input logic [3:0] kidx,
            input logic [31:0] kval, input logic [31:0] r1, input logic [31:0] r2,
            input logic [31:0] stop);
        t_outcome predicted;
        i_cmd <= cmd;
        i_knot_index <= kidx;
        i_knot_value <= kval;
        i_rand_first <= r1;
        i_rand_second <= r2;
        i_stop_time <= stop;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        predicted = advance_population(cmd, kidx, kval, r1, r2, stop);
        pending_outcomes.insert(pending_outcomes.size(), predicted);
        items_sent++;
    endtask

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // drop start and wait until every outcome has come back
    task automatic drain();
        start <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_uniform();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'd0;
        if (r < 6) return 32'd1;
        if (r < 9) return ALL32;
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_knot();
        return ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
    endfunction

    function automatic logic [31:0] rand_stop();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'd0;
        if (r < 10) return now_time;
        if (r < 20) return now_time + $urandom_range(1, 32'h0001_0000);
        if (r < 30) return $urandom;
        return ALL32;
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            send_item(CMD_LOAD, 4'($urandom), rand_knot(), $urandom, $urandom, $urandom);
        else if (r < 9)
            send_item(CMD_START, 4'($urandom), $urandom, rand_uniform(), rand_uniform(),
                $urandom);
        else if (r < 11)
            send_item(CMD_UNUSED, 4'($urandom), $urandom, $urandom, $urandom, $urandom);
        else
            send_item(CMD_STEP, 4'($urandom), $urandom, rand_uniform(), $urandom,
                rand_stop());
        idle_gap();
    endtask

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin
        t_outcome exp_out;
        if (i_rst_n && o_valid) begin
            case (o_event_kind)
                K_BIRTH: births++;
                K_DEATH: deaths++;
                K_NONE:  idles++;
                default: dones++;
            endcase
            if (pending_outcomes.size() == 0) begin
                $error("result transfer with no outcome pending");
                errors++;
            end else begin
                exp_out = pending_outcomes.pop_front();
                if (o_event_kind !== exp_out.kind) begin
                    $error("event_kind expected %0d got %0d", exp_out.kind, o_event_kind);
                    errors++;
                end
                if (o_cell_count !== exp_out.count) begin
                    $error("cell_count expected %0d got %0d", exp_out.count, o_cell_count);
                    errors++;
                end
                if (o_sim_time !== exp_out.simt) begin
                    $error("sim_time expected %h got %h", exp_out.simt, o_sim_time);
                    errors++;
                end
                if (o_birth_rate_now !== exp_out.rate) begin
                    $error("birth_rate_now expected %h got %h", exp_out.rate,
                        o_birth_rate_now);
                    errors++;
                end
            end
        end
    end

    // ---------------- tests ----------------

    // fill every knot first so no lookup ever reads an unwritten entry
    task automatic test_knot_load();
        for (int i = 0; i < KNOTS; i++)
            send_item(CMD_LOAD, 4'(i), (i == 3) ? ALL32 : (i == 5) ? 32'd0 :
                32'h0001_0000 + 32'(i) * 32'h0000_4000, $urandom, $urandom, $urandom);
        drain();
    endtask

    task automatic test_directed_steps();
        send_item(CMD_START, '0, '0, 32'h8000_0000, 32'h4000_0000, '0);
        send_item(CMD_STEP, '0, '0, ALL32, '0, ALL32);
        send_item(CMD_STEP, '0, '0, 32'd1, '0, ALL32);
        send_item(CMD_UNUSED, 4'hF, ALL32, ALL32, ALL32, ALL32);
        // time at or past stop
        send_item(CMD_STEP, '0, '0, 32'h1234_5678, '0, now_time);
        send_item(CMD_STEP, '0, '0, 32'h1234_5678, '0, 32'd0);
        // zero random inputs give the largest mark
        send_item(CMD_START, '0, '0, 32'd0, 32'd0, ALL32);
        send_item(CMD_STEP, '0, '0, 32'd0, '0, ALL32);
        drain();
    endtask

    task automatic test_config_phases();
        logic [31:0] init_v, coeff_v, end_v, kc_v, kv;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin init_v = 1; coeff_v = 0; end_v = 1; kc_v = 0; end
                1: begin init_v = 32'hFFFFF; coeff_v = ALL32; end_v = ALL32; kc_v = 31; end
                2: begin init_v = 2; coeff_v = 32'h100; end_v = 32'h10_0000; kc_v = 16; end
                default: begin
                    init_v = $urandom_range(1, 400);
                    coeff_v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h400);
                    end_v = ($urandom_range(0, 3) == 0) ? $urandom :
                        $urandom_range(1, 32'h0040_0000);
                    kc_v = $urandom_range(0, 31);
                end
            endcase
            write_reg(REG_INIT_COUNT, init_v);
            write_reg(REG_COEFF, coeff_v);
            write_reg(REG_END_TIME, end_v);
            write_reg(REG_KNOT_COUNT, kc_v);
            for (int i = 0; i < KNOTS; i++) begin
                kv = (ph == 0) ? 32'd0 : (ph == 1) ? ALL32 : rand_knot();
                send_item(CMD_LOAD, 4'(i), kv, $urandom, $urandom, $urandom);
                idle_gap();
            end
            send_item(CMD_START, '0, '0, rand_uniform(), rand_uniform(), '0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                // let the block drain mid-phase once
                if (ph == 3 && n == PHASE_ITEMS / 2) drain();
            end
            drain();
        end
    endtask

    initial begin
        for (int i = 0; i < KNOTS; i++) knot_rate[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_knot_load();
        test_directed_steps();
        test_config_phases();
        drain();
        repeat (400) @(posedge i_clk);
        $display("Ran %0d commands over %0d register settings: %0d births, %0d deaths,",
            items_sent, PHASES + 1, births, deaths);
        $display("%0d steps without an event, %0d loads and starts.", idles, dones);
        if (errors == 0 && pending_outcomes.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/lbd_pkg.sv
rtl/lbd_mul.sv
rtl/lbd_div.sv
rtl/logistic_birth_death_nrm_step.sv
tb/logistic_birth_death_nrm_step_tb.sv
